// File: design/int8_parity_bit_embedder_unit_macros.svh
// ---------------------------------------------------------------------------
// Int8 parity bit embedder assertion macros
// Shared concurrent assertion forms for the embedder checkers.
// ---------------------------------------------------------------------------
`ifndef INT8_PARITY_BIT_EMBEDDER_UNIT_MACROS_SVH
`define INT8_PARITY_BIT_EMBEDDER_UNIT_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define IPBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define IPBE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/ipbe_pkg.sv
// ---------------------------------------------------------------------------
// Int8 parity bit embedder package
// Sizes, constants and shared types of the embedder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipbe_pkg;

  localparam int NUM_BITS     = 8;
  localparam int MAX_ELEMENTS = 1024;

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int CLS_W  = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;
  localparam int IDX_W  = 10;
  localparam int BCLS_W = 5;
  localparam int ERR_W  = 41;
  localparam int INC_W  = 42;

  localparam logic signed [7:0]       CODE_MAX  = 8'sd127;
  localparam logic signed [7:0]       CODE_MIN  = -8'sd128;
  localparam logic signed [INC_W-1:0] INC_RESET = {1'b0, {(INC_W-1){1'b1}}};

  // Absolute errors of the current code and of its two neighbors.
  typedef struct packed {
    logic [ERR_W-1:0] cur_err;
    logic [ERR_W-1:0] up_err;
    logic [ERR_W-1:0] dn_err;
    logic [7:0]       code;
  } cand_t;

  // One class entry of the state memory.
  typedef struct packed {
    logic             par;
    logic [INC_W-1:0] inc;
    logic [IDX_W-1:0] elem;
    logic [7:0]       code;
  } ent_t;

  // One result word.
  typedef struct packed {
    logic [BCLS_W-1:0] bit_class;
    logic              apply_change;
    logic [IDX_W-1:0]  element_index;
    logic [7:0]        replacement_code;
    logic              too_short;
    logic              last_result;
  } res_t;

endpackage

// File: design/ipbe_in_if.sv
// ---------------------------------------------------------------------------
// Embedder input channel
// Valid/ready channel that carries one vector element per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipbe_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] original_value;
  logic signed [7:0]  quantized_value;
  logic [31:0]        step_size;
  logic [31:0]        hidden_bits;
  logic               is_last;

  modport source (
    output valid, original_value, quantized_value, step_size, hidden_bits, is_last,
    input  ready
  );
  modport sink (
    input  valid, original_value, quantized_value, step_size, hidden_bits, is_last,
    output ready
  );
endinterface

// File: design/ipbe_out_if.sv
// ---------------------------------------------------------------------------
// Embedder output channel
// Valid/ready channel that carries one per-class result per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipbe_out_if;
  logic              valid;
  logic              ready;
  logic [4:0]        bit_class;
  logic              apply_change;
  logic [9:0]        element_index;
  logic signed [7:0] replacement_code;
  logic              too_short;
  logic              last_result;

  modport source (
    output valid, bit_class, apply_change, element_index, replacement_code,
           too_short, last_result,
    input  ready
  );
  modport sink (
    input  valid, bit_class, apply_change, element_index, replacement_code,
           too_short, last_result,
    output ready
  );
endinterface

// File: design/ipbe_cand_eval.sv
// ---------------------------------------------------------------------------
// Embedder candidate evaluator
// Two-stage datapath giving the reconstruction errors of a code and of
// its +1 and -1 neighbors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipbe_cand_eval (
  input  logic               clk_i,
  input  logic               ld_i,
  input  logic signed [31:0] orig_i,
  input  logic signed [7:0]  code_i,
  input  logic [31:0]        step_i,
  output ipbe_pkg::cand_t    cand_o
);
  import ipbe_pkg::*;

  logic signed [40:0] prod_q;
  logic signed [39:0] tgt_q;
  logic [31:0]        step_q;
  logic [7:0]         code_q;

  logic signed [41:0] d0, dp, dm;
  cand_t              cand_q;

  // Stage one: the reconstruction of the current code and the Q.24 target.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      prod_q <= code_i * $signed({1'b0, step_i});
      tgt_q  <= {orig_i, 8'b0};
      step_q <= step_i;
      code_q <= code_i;
    end
  end

  // Neighbor reconstructions differ from the current one by one step.
  assign d0 = {prod_q[40], prod_q} - {{2{tgt_q[39]}}, tgt_q};
  assign dp = d0 + $signed({10'b0, step_q});
  assign dm = d0 - $signed({10'b0, step_q});

  // Stage two: magnitudes, which always fit in ERR_W bits.
  always_ff @(posedge clk_i) begin
    cand_q.cur_err <= d0[41] ? ERR_W'(-d0) : ERR_W'(d0);
    cand_q.up_err  <= dp[41] ? ERR_W'(-dp) : ERR_W'(dp);
    cand_q.dn_err  <= dm[41] ? ERR_W'(-dm) : ERR_W'(dm);
    cand_q.code    <= code_q;
  end

  assign cand_o = cand_q;
endmodule

// File: design/int8_parity_bit_embedder_unit.sv
// An accepted element passes through S_ERR, which reads its class entry, and S_UPD, which
// writes the entry back; no new element is taken until this read-modify-write is done.
// After the last element the sequencer runs S_ERR and S_UPD (not past the capacity), S_RD
// (not for a short vector) and S_OUT, which registers a result once the output register is
// free; each further class is read in S_RD in turn. A short vector gives one result.
// Reset (asynchronous, active low) clears the control state and the per-class valid bits.
// ---------------------------------------------------------------------------
// Int8 parity bit embedder
// Accumulates per-class code parity and the cheapest single-step code change
// over one quantized vector, then reports per class whether a change is due.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module int8_parity_bit_embedder_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipbe_in_if.sink   in_i,
  ipbe_out_if.source out_o
);
  import ipbe_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for an element word
    S_ERR  = 5'b00010,  // errors in flight, class entry being read
    S_UPD  = 5'b00100,  // compare candidates and write the entry back
    S_RD   = 5'b01000,  // read the entry of the class being reported
    S_OUT  = 5'b10000   // load one result into the output register
  } state_e;

  state_e state_q, state_d;

  // Vector bookkeeping.
  logic [CNT_W-1:0]    count_q;
  logic [CLS_W-1:0]    cls_q;
  logic [CLS_W-1:0]    emit_q;
  logic [NUM_BITS-1:0] vld_q;
  logic                last_q;
  logic                short_q;

  // Per-element payload captured at acceptance.
  logic [CLS_W-1:0] item_cls_q;
  logic [IDX_W-1:0] idx_q;
  logic [31:0]      hidden_q;

  // Class memory, one entry per bit class. The memory itself is never swept;
  // an entry without its valid bit reads as its reset contents.
  ent_t             mem [NUM_BITS];
  ent_t             rd_q;
  logic             rd_vld_q;
  logic             mem_re;
  logic             mem_we;
  logic [CLS_W-1:0] rd_addr;
  ent_t             wr_ent;

  // Output register.
  res_t out_q;
  logic out_vld_q;
  logic out_free;
  res_t res;

  logic             acc;
  logic             proc;
  logic [CNT_W-1:0] cnt_next;
  logic             short_now;
  logic             emit_end;
  logic             done;
  logic [CLS_W-1:0] cls_next;
  cand_t            cand;

  // Candidate selection.
  logic signed [INC_W-1:0] inc_up, inc_dn, best_inc;
  logic [IDX_W-1:0]        best_elem;
  logic [7:0]              best_code;
  logic                    base_par;

  // The block accepts a new element only between vectors' work steps, but it
  // does so even while a result still waits in the output register.
  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;

  // Elements past the capacity only count toward ending the vector.
  assign proc      = (count_q < CNT_W'(MAX_ELEMENTS));
  assign cnt_next  = count_q + CNT_W'(proc);
  assign short_now = (32'(cnt_next) < 32'(NUM_BITS));
  assign cls_next  = (cls_q == CLS_W'(NUM_BITS - 1)) ? '0 : CLS_W'(cls_q + 1'b1);

  assign out_free = !out_vld_q || out_o.ready;
  assign emit_end = short_q || (emit_q == CLS_W'(NUM_BITS - 1));
  assign done     = (state_q == S_OUT) && out_free && emit_end;

  ipbe_cand_eval u_eval (
    .clk_i  (clk_i),
    .ld_i   (acc),
    .orig_i (in_i.original_value),
    .code_i (in_i.quantized_value),
    .step_i (in_i.step_size),
    .cand_o (cand)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (proc) begin
            state_d = S_ERR;
          end else if (in_i.is_last) begin
            state_d = short_now ? S_OUT : S_RD;
          end
        end
      end
      S_ERR: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (last_q) begin
          state_d = short_q ? S_OUT : S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = emit_end ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cls_q   <= '0;
      emit_q  <= '0;
      vld_q   <= '0;
      last_q  <= 1'b0;
      short_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc) begin
        count_q <= cnt_next;
        last_q  <= in_i.is_last;
        short_q <= short_now;
        if (proc) begin
          cls_q <= cls_next;
        end
      end
      if (mem_we) begin
        vld_q[item_cls_q] <= 1'b1;
      end
      if (done) begin
        // The vector is finished: every class returns to its reset contents.
        count_q <= '0;
        cls_q   <= '0;
        emit_q  <= '0;
        vld_q   <= '0;
      end else if ((state_q == S_OUT) && out_free) begin
        emit_q <= CLS_W'(emit_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_cls_q <= cls_q;
      idx_q      <= IDX_W'(count_q);
      hidden_q   <= in_i.hidden_bits;
    end
  end

  // The class entry is read while the errors are computed, and written back
  // in the following cycle. Only one element is in flight, so a read never
  // meets a pending write to the same entry.
  assign mem_re  = (state_q == S_ERR) || (state_q == S_RD);
  assign mem_we  = (state_q == S_UPD);
  assign rd_addr = (state_q == S_RD) ? emit_q : item_cls_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[item_cls_q] <= wr_ent;
    end
    if (mem_re) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  // Error increases are exact; +1 is tried first and a later candidate wins
  // only when strictly cheaper.
  assign inc_up = $signed({1'b0, cand.up_err}) - $signed({1'b0, cand.cur_err});
  assign inc_dn = $signed({1'b0, cand.dn_err}) - $signed({1'b0, cand.cur_err});
  assign base_par = rd_vld_q && rd_q.par;

  always_comb begin
    best_inc  = rd_vld_q ? $signed(rd_q.inc) : INC_RESET;
    best_elem = rd_q.elem;
    best_code = rd_q.code;
    if ((cand.code != CODE_MAX) && (inc_up < best_inc)) begin
      best_inc  = inc_up;
      best_elem = idx_q;
      best_code = cand.code + 8'd1;
    end
    if ((cand.code != CODE_MIN) && (inc_dn < best_inc)) begin
      best_inc  = inc_dn;
      best_elem = idx_q;
      best_code = cand.code - 8'd1;
    end
    wr_ent.par  = base_par ^ cand.code[0];
    wr_ent.inc  = best_inc;
    wr_ent.elem = best_elem;
    wr_ent.code = best_code;
  end

  // Result of the class currently read, or the single short-vector result.
  always_comb begin
    res = '0;
    if (short_q) begin
      res.too_short   = 1'b1;
      res.last_result = 1'b1;
    end else begin
      res.bit_class        = BCLS_W'(emit_q);
      res.apply_change     = base_par != hidden_q[emit_q];
      res.element_index    = rd_q.elem;
      res.replacement_code = rd_q.code;
      res.last_result      = (emit_q == CLS_W'(NUM_BITS - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      out_q <= res;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.bit_class        = out_q.bit_class;
  assign out_o.apply_change     = out_q.apply_change;
  assign out_o.element_index    = out_q.element_index;
  assign out_o.replacement_code = out_q.replacement_code;
  assign out_o.too_short        = out_q.too_short;
  assign out_o.last_result      = out_q.last_result;

endmodule

// File: design/ipbe_checker.sv
// ---------------------------------------------------------------------------
// Int8 parity bit embedder checker
// Port-level assertions on the embedder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "int8_parity_bit_embedder_unit_macros.svh"

module ipbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  ipbe_in_if.sink   in_i,
  ipbe_out_if.source out_o
);
  import ipbe_pkg::*;

  // A stalled result word stays offered.
  `IPBE_ASSERT(a_out_hold, out_o.valid && !out_o.ready |=> out_o.valid, "result word dropped while stalled")

  // The final per-class result is the one of the highest class, and no other.
  `IPBE_ASSERT(a_last_class, out_o.valid && !out_o.too_short |-> (out_o.last_result == (out_o.bit_class == BCLS_W'(NUM_BITS - 1))), "last_result does not match the final class")

  // A short-vector result stands alone and carries no change.
  `IPBE_ASSERT(a_short_form, out_o.valid && out_o.too_short |-> out_o.last_result && !out_o.apply_change && (out_o.bit_class == '0), "malformed short-vector result")

  // No element is taken while a vector's results are still being issued.
  `IPBE_ASSERT(a_no_take_mid, out_o.valid && !out_o.last_result |-> !in_i.ready, "element accepted during result burst")

  // No result can appear in the cycle right after an element is accepted.
  `IPBE_ASSERT(a_no_early, in_i.valid && in_i.ready |=> !$rose(out_o.valid), "result appeared too early")

endmodule

bind int8_parity_bit_embedder_unit ipbe_checker u_ipbe_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
